[src/idq_pkg.sv]
`timescale 1ns / 1ps

package idq_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FRONT = 3'd4,
    OP_READ_BACK  = 3'd5,
    OP_READ_INDEX = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_OUT_OF_BOUND = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 8;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 9;

endpackage

[src/indexed_double_ended_queue_top.sv]
`timescale 1ns / 1ps

// Double-ended queue of DEPTH entries with push, pop and read at either end
// and read at a position counted from the front. An item is taken on every
// clock edge where start is high; busy never rises, so one item per cycle is
// sustained. Each item gives exactly one result, shown for a single cycle
// with out_strobe high in the cycle right after the item was taken; the
// result data comes from the registered read port of the element memory.
// The receiver cannot hold results off, so it must take each one in its
// strobe cycle. Entries are not cleared at reset; only ever-written
// entries are read back.
module indexed_double_ended_queue_top
  import idq_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic [POSITION_W-1:0] in_position,
  output logic                  out_strobe,
  output logic [DATA_W-1:0]     out_data,
  output logic [STATUS_W-1:0]   out_status,
  output logic [COUNT_W-1:0]    out_count
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  accept;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign wr_data = DATA_WIDTH'(in_value);

  idq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .position  (in_position),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_count (out_count)
  );

  idq_mem #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_data = DATA_W'(rd_data);

endmodule

[src/idq_mem.sv]
`timescale 1ns / 1ps

module idq_mem #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // An item that reads nothing returns zero data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/idq_ctrl.sv]
`timescale 1ns / 1ps

module idq_ctrl
  import idq_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [POSITION_W-1:0] position,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [COUNT_W-1:0]    out_count
);

  localparam int unsigned CW  = AW + 1;
  localparam int unsigned AW1 = AW + 1;
  localparam int unsigned OW  = (CW > POSITION_W) ? CW : POSITION_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          strobe_r;
  status_t       status_r, status_nxt;

  logic [AW-1:0] head_dec, head_inc;
  logic          is_full, is_empty, pos_out;
  op_t           op;

  // Ring slot of a logical offset from the front; offsets stay below DEPTH.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW1-1:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= AW1'(DEPTH)) begin
      sum = sum - AW1'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign op       = op_t'(opcode);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign pos_out  = (OW'(position) >= OW'(count_r));
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = head_dec;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    if (accept) begin
      unique case (op)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = slot(head_r, count_r[AW-1:0]);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = slot(head_r, AW'(count_r - CW'(1)));
            count_nxt = count_r - CW'(1);
          end
        end
        OP_READ_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_r;
          end
        end
        OP_READ_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot(head_r, AW'(count_r - CW'(1)));
          end
        end
        OP_READ_INDEX: begin
          if (pos_out) begin
            status_nxt = ST_OUT_OF_BOUND;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot(head_r, AW'(position));
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // The count register already holds the post-operation value during the
  // result cycle, since any following item only updates it at the next edge.
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_count  = COUNT_W'(count_r);

endmodule
